// ----- rtl/core/nprs_pkg.sv -----
package nprs_pkg;

    // Number format of all values.
    localparam int VALUE_WIDTH = 32;
    localparam int FRAC_BITS   = 16;

    // Derived widths of the datapath.
    localparam int TW   = 2 * VALUE_WIDTH + 3;          // signed stencil sum
    localparam int TMW  = 2 * VALUE_WIDTH + 2;          // its magnitude
    localparam int NW   = TMW + VALUE_WIDTH;            // numerator before the shift
    localparam int NSW  = NW + FRAC_BITS + 1;           // numerator as divided
    localparam int HW   = 2 * VALUE_WIDTH + 1;          // h * hb
    localparam int DW   = HW + VALUE_WIDTH;             // denominator
    localparam int QW   = VALUE_WIDTH + 2;              // quotient bits kept
    localparam int DSW  = DW + QW - 1;                  // aligned divisor
    localparam int CW   = $clog2(QW);                   // division step counter
    localparam int QDEPTH = 4;                          // job queue depth
    localparam int QPW  = $clog2(QDEPTH);

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_LEFT_BOUNDARY  = 2'd0,
        CFG_RIGHT_BOUNDARY = 2'd1,
        CFG_FIRST_GAP      = 2'd2,
        CFG_SCALE          = 2'd3
    } cfg_index_t;

    // One point to evaluate, handed from the front to the back.
    typedef struct packed {
        logic [VALUE_WIDTH-1:0] up;
        logic [VALUE_WIDTH-1:0] u;
        logic [VALUE_WIDTH-1:0] un;
        logic [VALUE_WIDTH-1:0] hb;
        logic [VALUE_WIDTH-1:0] hf;
        logic                   last;
    } job_t;

    // Back-end sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_DIV,
        ST_ROUND,
        ST_OUT
    } back_state_t;

    // Magnitude of a two's complement value; the most negative value fits unsigned.
    function automatic logic [VALUE_WIDTH-1:0] mag(input logic [VALUE_WIDTH-1:0] v);
        mag = v[VALUE_WIDTH-1] ? (~v + 1'b1) : v;
    endfunction

endpackage

// ----- rtl/core/nprs_queue.sv -----
module nprs_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  nprs_pkg::job_t    push_job,
    output logic              full,
    input  logic              pop,
    output logic              empty,
    output nprs_pkg::job_t    head_job
);

    nprs_pkg::job_t              mem_reg [nprs_pkg::QDEPTH];
    logic [nprs_pkg::QPW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [nprs_pkg::QPW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [nprs_pkg::QPW:0]      count_reg, count_next;

    assign full     = (count_reg == (nprs_pkg::QPW+1)'(nprs_pkg::QDEPTH));
    assign empty    = (count_reg == '0);
    assign head_job = mem_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + ((push && !full) ? 1'b1 : 1'b0);
        rd_ptr_next = rd_ptr_reg + ((pop && !empty) ? 1'b1 : 1'b0);
        count_next  = count_reg;
        if ((push && !full) && !(pop && !empty))
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!(push && !full) && (pop && !empty))
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ----- rtl/core/nprs_front.sv -----
module nprs_front
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [nprs_pkg::VALUE_WIDTH-1:0]   sample,
    input  logic [nprs_pkg::VALUE_WIDTH-1:0]   spacing_after,
    input  logic                               last,
    input  logic                               cfg_we,
    input  logic [1:0]                         cfg_index,
    input  logic [nprs_pkg::VALUE_WIDTH-1:0]   cfg_data,
    output logic [nprs_pkg::VALUE_WIDTH-1:0]   scale,
    output logic                               push,
    output nprs_pkg::job_t                     push_job,
    input  logic                               full
);

    logic [nprs_pkg::VALUE_WIDTH-1:0] left_reg, right_reg, first_gap_reg, scale_reg;
    logic [nprs_pkg::VALUE_WIDTH-1:0] prev_reg, prev_next;
    logic [nprs_pkg::VALUE_WIDTH-1:0] held_reg, held_next;
    logic [nprs_pkg::VALUE_WIDTH-1:0] back_gap_reg, back_gap_next;
    logic [nprs_pkg::VALUE_WIDTH-1:0] fwd_gap_reg, fwd_gap_next;
    logic                             have_reg, have_next;
    logic                             pend_reg, pend_next;
    nprs_pkg::job_t                   pend_job_reg, pend_job_next;
    logic                             accept;

    assign scale    = scale_reg;
    assign s_tready = !pend_reg && !full;
    assign accept   = s_tvalid && s_tready;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg      <= '0;
            right_reg     <= '0;
            first_gap_reg <= nprs_pkg::VALUE_WIDTH'(1) << nprs_pkg::FRAC_BITS;
            scale_reg     <= nprs_pkg::VALUE_WIDTH'(1) << nprs_pkg::FRAC_BITS;
        end
        else if (cfg_we)
        begin
            unique case (nprs_pkg::cfg_index_t'(cfg_index))
                nprs_pkg::CFG_LEFT_BOUNDARY:  left_reg      <= cfg_data;
                nprs_pkg::CFG_RIGHT_BOUNDARY: right_reg     <= cfg_data;
                nprs_pkg::CFG_FIRST_GAP:      first_gap_reg <= cfg_data;
                nprs_pkg::CFG_SCALE:          scale_reg     <= cfg_data;
                default:                      left_reg      <= left_reg;
            endcase
        end
    end

    // Classify each word into zero, one or two point jobs.
    always_comb
    begin
        prev_next     = prev_reg;
        held_next     = held_reg;
        back_gap_next = back_gap_reg;
        fwd_gap_next  = fwd_gap_reg;
        have_next     = have_reg;
        pend_next     = pend_reg;
        pend_job_next = pend_job_reg;
        push          = 1'b0;
        push_job      = pend_job_reg;

        if (pend_reg)
        begin
            // The final point of a grid waits behind the held point.
            if (!full)
            begin
                push      = 1'b1;
                pend_next = 1'b0;
            end
        end
        else if (accept)
        begin
            if (have_reg)
            begin
                push          = 1'b1;
                push_job.up   = prev_reg;
                push_job.u    = held_reg;
                push_job.un   = sample;
                push_job.hb   = back_gap_reg;
                push_job.hf   = fwd_gap_reg;
                push_job.last = 1'b0;
                if (last)
                begin
                    pend_next          = 1'b1;
                    pend_job_next.up   = held_reg;
                    pend_job_next.u    = sample;
                    pend_job_next.un   = right_reg;
                    pend_job_next.hb   = fwd_gap_reg;
                    pend_job_next.hf   = spacing_after;
                    pend_job_next.last = 1'b1;
                end
            end
            else if (last)
            begin
                push          = 1'b1;
                push_job.up   = left_reg;
                push_job.u    = sample;
                push_job.un   = right_reg;
                push_job.hb   = first_gap_reg;
                push_job.hf   = spacing_after;
                push_job.last = 1'b1;
            end

            if (last)
            begin
                prev_next     = '0;
                held_next     = '0;
                back_gap_next = '0;
                fwd_gap_next  = '0;
                have_next     = 1'b0;
            end
            else
            begin
                prev_next     = have_reg ? held_reg : left_reg;
                held_next     = sample;
                back_gap_next = have_reg ? fwd_gap_reg : first_gap_reg;
                fwd_gap_next  = spacing_after;
                have_next     = 1'b1;
            end
        end
    end

    // Grid walk state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg     <= '0;
            held_reg     <= '0;
            back_gap_reg <= '0;
            fwd_gap_reg  <= '0;
            have_reg     <= 1'b0;
            pend_reg     <= 1'b0;
        end
        else
        begin
            prev_reg     <= prev_next;
            held_reg     <= held_next;
            back_gap_reg <= back_gap_next;
            fwd_gap_reg  <= fwd_gap_next;
            have_reg     <= have_next;
            pend_reg     <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_job_reg <= pend_job_next;
    end

endmodule

// ----- rtl/core/nprs_back.sv -----
module nprs_back
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               empty,
    input  nprs_pkg::job_t                     head_job,
    output logic                               pop,
    input  logic [nprs_pkg::VALUE_WIDTH-1:0]   scale,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [nprs_pkg::VALUE_WIDTH-1:0]   residual,
    output logic                               last_point,
    output logic                               saturated,
    output logic                               bad_spacing
);

    localparam int VW = nprs_pkg::VALUE_WIDTH;

    // Multiply steps of the sequencer.
    localparam logic [3:0] STEP_T0   = 4'd0;
    localparam logic [3:0] STEP_T1   = 4'd1;
    localparam logic [3:0] STEP_T2   = 4'd2;
    localparam logic [3:0] STEP_T3   = 4'd3;
    localparam logic [3:0] STEP_HH0  = 4'd4;
    localparam logic [3:0] STEP_HH1  = 4'd5;
    localparam logic [3:0] STEP_N0   = 4'd6;
    localparam logic [3:0] STEP_N1   = 4'd7;
    localparam logic [3:0] STEP_N2   = 4'd8;
    localparam logic [3:0] STEP_D0   = 4'd9;
    localparam logic [3:0] STEP_D1   = 4'd10;
    localparam logic [3:0] STEP_D2   = 4'd11;

    nprs_pkg::back_state_t            state_reg, state_next;
    nprs_pkg::job_t                   job_reg, job_next;
    logic [3:0]                       step_reg, step_next;
    logic [2*VW-1:0]                  prod_reg, prod_next;
    logic signed [nprs_pkg::TW-1:0]   t_reg, t_next;
    logic [nprs_pkg::NW-1:0]          num_reg, num_next;
    logic [nprs_pkg::HW-1:0]          hh_reg, hh_next;
    logic [nprs_pkg::DW-1:0]          den_reg, den_next;
    logic [nprs_pkg::NSW-1:0]         rem_reg, rem_next;
    logic [nprs_pkg::DSW-1:0]         dsr_reg, dsr_next;
    logic [nprs_pkg::QW-1:0]          q_reg, q_next;
    logic [nprs_pkg::CW-1:0]          cnt_reg, cnt_next;
    logic [VW-1:0]                    res_reg, res_next;
    logic                             sat_reg, sat_next;
    logic                             bad_reg, bad_next;
    logic                             ovalid_reg, ovalid_next;
    logic [VW-1:0]                    ores_reg, ores_next;
    logic                             olast_reg, olast_next;
    logic                             osat_reg, osat_next;
    logic                             obad_reg, obad_next;

    logic [VW-1:0]                    mul_a, mul_b;
    logic                             mul_sub;
    logic [nprs_pkg::TMW-1:0]         tmag;
    logic [VW-1:0]                    smag;
    logic                             ge;
    logic                             round_up;
    logic [nprs_pkg::QW:0]            qr, lim, qsel;
    logic                             rneg, over;

    assign m_tvalid    = ovalid_reg;
    assign residual    = ores_reg;
    assign last_point  = olast_reg;
    assign saturated   = osat_reg;
    assign bad_spacing = obad_reg;

    assign smag = nprs_pkg::mag(scale);
    assign tmag = t_reg[nprs_pkg::TW-1] ? nprs_pkg::TMW'(-t_reg) : nprs_pkg::TMW'(t_reg);
    assign ge   = ({{(nprs_pkg::DSW-nprs_pkg::NSW){1'b0}}, rem_reg} >= dsr_reg);

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_a   = '0;
        mul_b   = '0;
        mul_sub = 1'b0;
        unique case (step_reg)
            STEP_T0:
            begin
                mul_a = job_reg.hb; mul_b = nprs_pkg::mag(job_reg.un);
                mul_sub = job_reg.un[VW-1];
            end
            STEP_T1:
            begin
                mul_a = job_reg.hf; mul_b = nprs_pkg::mag(job_reg.up);
                mul_sub = job_reg.up[VW-1];
            end
            STEP_T2:
            begin
                mul_a = job_reg.hb; mul_b = nprs_pkg::mag(job_reg.u);
                mul_sub = !job_reg.u[VW-1];
            end
            STEP_T3:
            begin
                mul_a = job_reg.hf; mul_b = nprs_pkg::mag(job_reg.u);
                mul_sub = !job_reg.u[VW-1];
            end
            STEP_HH0: begin mul_a = job_reg.hb; mul_b = job_reg.hb; end
            STEP_HH1: begin mul_a = job_reg.hf; mul_b = job_reg.hb; end
            STEP_N0:  begin mul_a = tmag[VW-1:0];      mul_b = smag; end
            STEP_N1:  begin mul_a = tmag[2*VW-1:VW];   mul_b = smag; end
            STEP_N2:
            begin
                mul_a = VW'(tmag[nprs_pkg::TMW-1:2*VW]); mul_b = smag;
            end
            STEP_D0:  begin mul_a = hh_reg[VW-1:0];    mul_b = job_reg.hf; end
            STEP_D1:  begin mul_a = hh_reg[2*VW-1:VW]; mul_b = job_reg.hf; end
            STEP_D2:
            begin
                mul_a = VW'(hh_reg[nprs_pkg::HW-1:2*VW]); mul_b = job_reg.hf;
            end
            default:  begin mul_a = '0; mul_b = '0; end
        endcase
    end

    // Rounding and saturation of the quotient.
    always_comb
    begin
        round_up = ({rem_reg[nprs_pkg::DW-1:0], 1'b0} >= {1'b0, den_reg});
        qr       = {1'b0, q_reg} + (nprs_pkg::QW+1)'(round_up);
        rneg     = (scale[VW-1] == t_reg[nprs_pkg::TW-1]);
        lim      = ((nprs_pkg::QW+1)'(1) << (VW - 1)) - (rneg ? 1'b0 : 1'b1);
        over     = (qr > lim);
        qsel     = over ? lim : qr;
    end

    // Sequencer: products, long division, rounding, output register.
    always_comb
    begin
        state_next  = state_reg;
        job_next    = job_reg;
        step_next   = step_reg;
        prod_next   = prod_reg;
        t_next      = t_reg;
        num_next    = num_reg;
        hh_next     = hh_reg;
        den_next    = den_reg;
        rem_next    = rem_reg;
        dsr_next    = dsr_reg;
        q_next      = q_reg;
        cnt_next    = cnt_reg;
        res_next    = res_reg;
        sat_next    = sat_reg;
        bad_next    = bad_reg;
        ovalid_next = ovalid_reg && !m_tready;
        ores_next   = ores_reg;
        olast_next  = olast_reg;
        osat_next   = osat_reg;
        obad_next   = obad_reg;
        pop         = 1'b0;

        unique case (state_reg)
            nprs_pkg::ST_IDLE:
            begin
                if (!empty)
                begin
                    pop       = 1'b1;
                    job_next  = head_job;
                    step_next = STEP_T0;
                    t_next    = '0;
                    num_next  = '0;
                    hh_next   = '0;
                    den_next  = '0;
                    q_next    = '0;
                    if (head_job.hb == '0 || head_job.hf == '0)
                    begin
                        res_next   = '0;
                        sat_next   = 1'b0;
                        bad_next   = 1'b1;
                        state_next = nprs_pkg::ST_OUT;
                    end
                    else
                    begin
                        bad_next   = 1'b0;
                        state_next = nprs_pkg::ST_MUL;
                    end
                end
            end

            nprs_pkg::ST_MUL:
            begin
                prod_next  = mul_a * mul_b;
                state_next = nprs_pkg::ST_ACC;
            end

            nprs_pkg::ST_ACC:
            begin
                state_next = nprs_pkg::ST_MUL;
                step_next  = step_reg + 1'b1;
                priority if (step_reg <= STEP_T3)
                begin
                    if (mul_sub)
                        t_next = t_reg - nprs_pkg::TW'(prod_reg);
                    else
                        t_next = t_reg + nprs_pkg::TW'(prod_reg);
                end
                else if (step_reg <= STEP_HH1)
                begin
                    hh_next = hh_reg + nprs_pkg::HW'(prod_reg);
                end
                else if (step_reg <= STEP_N2)
                begin
                    num_next = num_reg + (nprs_pkg::NW'(prod_reg)
                               << (VW * 32'(step_reg - STEP_N0)));
                end
                else
                begin
                    den_next = den_reg + (nprs_pkg::DW'(prod_reg)
                               << (VW * 32'(step_reg - STEP_D0)));
                    if (step_reg == STEP_D2)
                    begin
                        rem_next   = nprs_pkg::NSW'(num_reg) << (nprs_pkg::FRAC_BITS + 1);
                        dsr_next   = nprs_pkg::DSW'(den_next) << (nprs_pkg::QW - 1);
                        cnt_next   = nprs_pkg::CW'(nprs_pkg::QW - 1);
                        state_next = nprs_pkg::ST_DIV;
                    end
                end
            end

            nprs_pkg::ST_DIV:
            begin
                // One quotient bit per cycle.
                if (ge)
                    rem_next = rem_reg - dsr_reg[nprs_pkg::NSW-1:0];
                q_next   = {q_reg[nprs_pkg::QW-2:0], ge};
                dsr_next = dsr_reg >> 1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = nprs_pkg::ST_ROUND;
            end

            nprs_pkg::ST_ROUND:
            begin
                res_next   = rneg ? (~qsel[VW-1:0] + 1'b1) : qsel[VW-1:0];
                sat_next   = over;
                state_next = nprs_pkg::ST_OUT;
            end

            nprs_pkg::ST_OUT:
            begin
                if (!ovalid_reg || m_tready)
                begin
                    ovalid_next = 1'b1;
                    ores_next   = res_reg;
                    olast_next  = job_reg.last;
                    osat_next   = sat_reg;
                    obad_next   = bad_reg;
                    state_next  = nprs_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = nprs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= nprs_pkg::ST_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        job_reg  <= job_next;
        step_reg <= step_next;
        prod_reg <= prod_next;
        t_reg    <= t_next;
        num_reg  <= num_next;
        hh_reg   <= hh_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
        q_reg    <= q_next;
        cnt_reg  <= cnt_next;
        res_reg  <= res_next;
        sat_reg  <= sat_next;
        bad_reg  <= bad_next;
        ores_reg <= ores_next;
        olast_reg <= olast_next;
        osat_reg <= osat_next;
        obad_reg <= obad_next;
    end

endmodule

// ----- rtl/core/nonuniform_poisson_residual.sv -----
// Channel  | Direction | Word contents (lowest bit first)
// s_*      | in        | tdata: sample[31:0], spacing_after[63:32]; tlast: last
// m_*      | out       | tdata: residual; tlast: last_point; tuser: saturated, bad_spacing
// cfg_*    | in        | write enable, index 0..3, 32-bit data
//
// The back end takes a job, forms 12 products on one shared 32x32
// multiplier, each in a multiply and an accumulate state, runs a
// restoring division of 34 quotient bits, rounds, and loads the output
// register; a zero spacing goes from taking the job to the output.
// A four-entry job queue lets the front take words while the back end
// works or the output register waits. Reset is asynchronous, active low.
module nonuniform_poisson_residual
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [2*nprs_pkg::VALUE_WIDTH-1:0] s_tdata,   // sample, spacing_after
    input  logic                               s_tlast,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [nprs_pkg::VALUE_WIDTH-1:0]   m_tdata,   // residual
    output logic                               m_tlast,
    output logic [1:0]                         m_tuser,   // saturated, bad_spacing
    input  logic                               cfg_we,
    input  logic [1:0]                         cfg_index,
    input  logic [nprs_pkg::VALUE_WIDTH-1:0]   cfg_data
);

    localparam int VW = nprs_pkg::VALUE_WIDTH;

    logic            push, full, pop, empty;
    nprs_pkg::job_t  push_job, head_job;
    logic [VW-1:0]   scale;

    // Front: grid walk and configuration.
    nprs_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .sample        (s_tdata[VW-1:0]),
        .spacing_after (s_tdata[2*VW-1:VW]),
        .last          (s_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .scale         (scale),
        .push          (push),
        .push_job      (push_job),
        .full          (full)
    );

    // Job queue between front and back.
    nprs_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (full),
        .pop      (pop),
        .empty    (empty),
        .head_job (head_job)
    );

    // Back: arithmetic and output register.
    nprs_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .empty       (empty),
        .head_job    (head_job),
        .pop         (pop),
        .scale       (scale),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .residual    (m_tdata),
        .last_point  (m_tlast),
        .saturated   (m_tuser[0]),
        .bad_spacing (m_tuser[1])
    );

endmodule

// ----- sim/tb_nonuniform_poisson_residual.sv -----
`timescale 1ns / 1ps

module tb_nonuniform_poisson_residual;

    localparam int  CYCLE_LIMIT  = 1000000;
    localparam int  SETTLE       = 150;
    localparam int  PHASE_WORDS  = 165;

    // One expected or observed output word.
    typedef struct {
        logic [31:0] residual;
        logic        last_point;
        logic        saturated;
        logic        bad_spacing;
    } point_result_t;

    // Predicts the residual words of a grid stream and compares them against the block.
    class residual_scoreboard;
        point_result_t expected_words[$];
        int            mismatches;
        logic [31:0]   left_bnd, right_bnd, start_gap, eps;
        logic [31:0]   prev_u, held_u, gap_back, gap_fwd;
        bit            holding;

        function void clear();
            left_bnd  = 0;
            right_bnd = 0;
            start_gap = 32'h0001_0000;
            eps       = 32'h0001_0000;
            prev_u    = 0;
            held_u    = 0;
            gap_back  = 0;
            gap_fwd   = 0;
            holding   = 0;
            mismatches = 0;
        endfunction

        function void write_reg(nprs_pkg::cfg_index_t idx, logic [31:0] value);
            case (idx)
                nprs_pkg::CFG_LEFT_BOUNDARY:  left_bnd  = value;
                nprs_pkg::CFG_RIGHT_BOUNDARY: right_bnd = value;
                nprs_pkg::CFG_FIRST_GAP:      start_gap = value;
                nprs_pkg::CFG_SCALE:          eps       = value;
            endcase
        endfunction

        // Exact stencil value, rounded half away from zero, then saturated.
        function point_result_t stencil(logic [31:0] up, logic [31:0] u, logic [31:0] un,
                                        logic [31:0] hb, logic [31:0] hf, logic lastp);
            point_result_t       res;
            logic signed [79:0]  sum;
            logic [79:0]         tmag;
            logic [32:0]         h;
            logic [32:0]         smag;
            logic [191:0]        num, den, quo, rem, lim;
            bit                  tneg, sneg, rneg;
            res.last_point = lastp;
            if (hb == 0 || hf == 0)
            begin
                res.residual    = 0;
                res.saturated   = 0;
                res.bad_spacing = 1;
                return res;
            end
            h = {1'b0, hb} + {1'b0, hf};
            sum = $signed({48'b0, hb}) * $signed({{48{un[31]}}, un})
                + $signed({48'b0, hf}) * $signed({{48{up[31]}}, up})
                - $signed({47'b0, h}) * $signed({{48{u[31]}}, u});
            tneg = sum < 0;
            tmag = tneg ? -sum : sum;
            sneg = eps[31];
            smag = sneg ? {1'b0, ~eps + 32'd1} : {1'b0, eps};
            num = tmag;
            num = num * smag;
            num = num << (nprs_pkg::FRAC_BITS + 1);
            den = h;
            den = den * hb;
            den = den * hf;
            quo = num / den;
            rem = num % den;
            if (rem * 2 >= den)
                quo = quo + 1;
            // The result is -scale * sum, so it is negative when both signs agree.
            rneg = (sneg == tneg);
            lim  = rneg ? 192'h8000_0000 : 192'h7FFF_FFFF;
            res.saturated = quo > lim;
            if (res.saturated)
                quo = lim;
            res.residual    = rneg ? (~quo[31:0] + 32'd1) : quo[31:0];
            res.bad_spacing = 0;
            return res;
        endfunction

        // Accepted input word: release the held point and, on the last word, the final one.
        function void note_word(logic [31:0] u, logic [31:0] hf, logic lastw);
            logic [31:0] pv, hb;
            if (holding)
            begin
                expected_words.push_back(stencil(prev_u, held_u, u, gap_back, gap_fwd, 0));
                pv = held_u;
                hb = gap_fwd;
            end
            else
            begin
                pv = left_bnd;
                hb = start_gap;
            end
            if (lastw)
            begin
                expected_words.push_back(stencil(pv, u, right_bnd, hb, hf, 1));
                prev_u = 0; held_u = 0; gap_back = 0; gap_fwd = 0; holding = 0;
            end
            else
            begin
                prev_u = pv; held_u = u; gap_back = hb; gap_fwd = hf; holding = 1;
            end
        endfunction

        function void check_word(point_result_t got);
            point_result_t want;
            if (expected_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected output word: residual %h", got.residual);
                return;
            end
            want = expected_words.pop_front();
            if (got.residual !== want.residual || got.last_point !== want.last_point ||
                got.saturated !== want.saturated || got.bad_spacing !== want.bad_spacing)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"Mismatch: expected res %h last %b sat %b bad %b, ",
                              "got res %h last %b sat %b bad %b"},
                             want.residual, want.last_point, want.saturated,
                             want.bad_spacing, got.residual, got.last_point,
                             got.saturated, got.bad_spacing);
            end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [63:0] s_tdata = 0;
    logic        s_tlast = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic [1:0]  m_tuser;
    logic        cfg_we = 0;
    logic [1:0]  cfg_index = 0;
    logic [31:0] cfg_data = 0;

    residual_scoreboard grid_check;
    int sender_idle_pct   = 0;
    int receiver_idle_pct = 0;
    int cycles = 0;
    int words_sent = 0;

    nonuniform_poisson_residual i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Receiver back-pressure.
    always @(negedge clk)
        m_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);

    // Check every output word taken by the receiver.
    always @(posedge clk)
    begin
        point_result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.residual    = m_tdata;
            got.last_point  = m_tlast;
            got.saturated   = m_tuser[0];
            got.bad_spacing = m_tuser[1];
            grid_check.check_word(got);
        end
    end

    task automatic write_cfg(nprs_pkg::cfg_index_t idx, logic [31:0] value);
        @(negedge clk);
        cfg_we    <= 1;
        cfg_index <= idx;
        cfg_data  <= value;
        grid_check.write_reg(idx, value);
        @(negedge clk);
        cfg_we <= 0;
    endtask

    // Offer one word, with random idle cycles ahead of it, and wait for acceptance.
    task automatic send_word(logic [31:0] u, logic [31:0] hf, logic lastw);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            @(negedge clk);
            s_tvalid <= 0;
        end
        @(negedge clk);
        s_tvalid <= 1;
        s_tdata  <= {hf, u};
        s_tlast  <= lastw;
        do
            @(posedge clk);
        while (!s_tready);
        grid_check.note_word(u, hf, lastw);
        words_sent++;
    endtask

    // Drain all expected words, then give the back end time to go quiet.
    task automatic settle();
        @(negedge clk);
        s_tvalid <= 0;
        while (grid_check.expected_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_spacing();
        int k;
        k = $urandom_range(0, 19);
        if (k == 0)
            return 0;
        else if (k <= 4)
            return $urandom;
        else if (k == 5)
            return $urandom_range(1, 16);
        return $urandom_range(1 << 12, 1 << 18);
    endfunction

    function automatic logic [31:0] pick_sample();
        if ($urandom_range(0, 2) == 0)
            return $urandom;
        return $urandom_range(0, 1 << 21) - (1 << 20);
    endfunction

    // One grid of random length, ending on a last word.
    task automatic send_grid();
        int len;
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++)
            send_word(pick_sample(), pick_spacing(), i == len - 1);
    endtask

    initial
    begin
        logic [31:0] lb, rb, fg, sc;
        int phase_start;
        grid_check = new();
        grid_check.clear();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;

        // Directed words with the reset configuration.
        send_word(32'h0002_0000, 32'h0001_0000, 1);
        send_word(32'h0001_0000, 32'h0000_8000, 0);
        send_word(32'hFFFF_0000, 32'h0002_0000, 0);
        send_word(32'h0000_4000, 32'h0001_0000, 1);
        send_word(32'h7FFF_FFFF, 32'h0000_0001, 0);
        send_word(32'h8000_0000, 32'h0000_0001, 0);
        send_word(32'h7FFF_FFFF, 32'h0000_0001, 1);
        send_word(32'h1234_5678, 32'h0000_0000, 0);
        send_word(32'h0000_0000, 32'h0001_0000, 1);
        send_word(32'h0000_0000, 32'h0000_0000, 1);
        send_word(32'h8000_0000, 32'hFFFF_FFFF, 0);
        send_word(32'h7FFF_FFFF, 32'hFFFF_FFFF, 1);
        send_word(32'hFFFF_FFFF, 32'h0000_0001, 1);
        send_word(32'h5555_5555, 32'hAAAA_AAAA, 0);
        send_word(32'hAAAA_AAAA, 32'h5555_5555, 1);
        settle();

        // Random phases, each with its own register setting; the idle pattern changes every two phases.
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:
                begin
                    lb = 32'h8000_0000; rb = 32'h7FFF_FFFF;
                    fg = 32'hFFFF_FFFF; sc = 32'h8000_0000;
                end
                1:
                begin
                    lb = 32'h7FFF_FFFF; rb = 32'h8000_0000;
                    fg = 32'h0000_0000; sc = 32'h7FFF_FFFF;
                end
                2: begin lb = 32'h0; rb = 32'h0; fg = 32'h0000_0001; sc = 32'h0; end
                default:
                begin
                    lb = pick_sample();
                    rb = pick_sample();
                    fg = pick_spacing() | 32'h1;
                    sc = $urandom_range(0, 1 << 19) - (1 << 18);
                end
            endcase
            write_cfg(nprs_pkg::CFG_LEFT_BOUNDARY, lb);
            write_cfg(nprs_pkg::CFG_RIGHT_BOUNDARY, rb);
            write_cfg(nprs_pkg::CFG_FIRST_GAP, fg);
            write_cfg(nprs_pkg::CFG_SCALE, sc);
            sender_idle_pct   = (phase < 2) ? 31 : (phase < 4) ? 52 : 0;
            receiver_idle_pct = (phase < 2) ? 52 : (phase < 4) ? 31 : 0;
            phase_start = words_sent;
            while (words_sent - phase_start < PHASE_WORDS)
                send_grid();
            settle();
        end

        if (grid_check.mismatches == 0 && grid_check.expected_words.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- nonuniform_poisson_residual.f -----
rtl/core/nprs_pkg.sv
rtl/core/nprs_queue.sv
rtl/core/nprs_front.sv
rtl/core/nprs_back.sv
rtl/core/nonuniform_poisson_residual.sv
sim/tb_nonuniform_poisson_residual.sv
